[hw/rtl/keyboard_matrix_port_unit_defines.svh]
// ----------------------------------------------------------------------------
// Keyboard matrix port unit assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_MATRIX_PORT_UNIT_DEFINES_SVH
`define KEYBOARD_MATRIX_PORT_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define KMP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("keyboard matrix port check failed");

// next-cycle implication, disabled while in reset
`define KMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("keyboard matrix port check failed");

`endif

[hw/rtl/kmp_pkg.sv]
// ----------------------------------------------------------------------------
// Keyboard matrix port package
// Item kinds, port decode constants and the key code table.
// ----------------------------------------------------------------------------
package kmp_pkg;

	localparam int ROWS   = 8;
	localparam int ROW_W  = 3;
	localparam int SCAN_W = 3;

	typedef enum logic [1:0] {
		KIND_PRESS   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_READ    = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	localparam logic [7:0] KB_PORT        = 8'hFE;
	localparam logic [7:0] INJECT_ROW_SEL = 8'hFE;
	localparam logic [7:0] HOLD_ROW_SEL   = 8'hFD;
	localparam logic [7:0] NEWLINE        = 8'h0A;
	localparam logic [7:0] IDLE_BYTE      = 8'hFF;

	typedef struct packed {
		logic             use1;
		logic [ROW_W-1:0] row1;
		logic [7:0]       mask1;
		logic             use2;
		logic [ROW_W-1:0] row2;
		logic [7:0]       mask2;
	} key_entry_t;

	function automatic key_entry_t k2(input logic [2:0] r1, input logic [7:0] m1,
			input logic [2:0] r2, input logic [7:0] m2);
		key_entry_t e;
		e = '{use1: 1'b1, row1: r1, mask1: m1, use2: 1'b1, row2: r2, mask2: m2};
		return e;
	endfunction

	function automatic key_entry_t k1(input logic [2:0] r1, input logic [7:0] m1);
		key_entry_t e;
		e = '{use1: 1'b1, row1: r1, mask1: m1, use2: 1'b0, row2: '0, mask2: 8'hFF};
		return e;
	endfunction

	// unknown codes map to an entry that touches no row
	function automatic key_entry_t key_lookup(input logic [7:0] code);
		key_entry_t e;
		e = '{use1: 1'b0, row1: '0, mask1: 8'hFF, use2: 1'b0, row2: '0, mask2: 8'hFF};
		case (code)
			8'h01: e = k2(3'd3, 8'hfe, 3'd0, 8'hfe);
			8'h02: e = k2(3'd3, 8'hf7, 3'd0, 8'hfe);
			8'h03: e = k2(3'd4, 8'hfd, 3'd0, 8'hfe);
			8'h04: e = k2(3'd3, 8'hef, 3'd0, 8'hfe);
			8'h05: e = k2(3'd4, 8'hf7, 3'd0, 8'hfe);
			8'h06: e = k2(3'd4, 8'hef, 3'd0, 8'hfe);
			8'h07: e = k2(3'd4, 8'hfb, 3'd0, 8'hfe);
			8'h08: e = k2(3'd0, 8'hfe, 3'd4, 8'hfe);
			8'h31: e = k1(3'd3, 8'hfe);
			8'h32: e = k1(3'd3, 8'hfd);
			8'h33: e = k1(3'd3, 8'hfb);
			8'h34: e = k1(3'd3, 8'hf7);
			8'h35: e = k1(3'd3, 8'hef);
			8'h36: e = k1(3'd4, 8'hef);
			8'h37: e = k1(3'd4, 8'hf7);
			8'h38: e = k1(3'd4, 8'hfb);
			8'h39: e = k1(3'd4, 8'hfd);
			8'h30: e = k1(3'd4, 8'hfe);
			8'h21: e = k2(3'd3, 8'hfe, 3'd0, 8'hfd);
			8'h40: e = k2(3'd3, 8'hfd, 3'd0, 8'hfd);
			8'h23: e = k2(3'd3, 8'hfb, 3'd0, 8'hfd);
			8'h24: e = k2(3'd3, 8'hf7, 3'd0, 8'hfd);
			8'h25: e = k2(3'd3, 8'hef, 3'd0, 8'hfd);
			8'h26: e = k2(3'd7, 8'hfe, 3'd0, 8'hfe); // Break wins the shared code
			8'h27: e = k2(3'd4, 8'hf7, 3'd0, 8'hfd);
			8'h28: e = k2(3'd4, 8'hfb, 3'd0, 8'hfd);
			8'h29: e = k2(3'd4, 8'hfd, 3'd0, 8'hfd);
			8'h5f: e = k2(3'd4, 8'hfe, 3'd0, 8'hfd);
			8'h41: e = k2(3'd0, 8'hfe, 3'd1, 8'hfe);
			8'h61: e = k1(3'd1, 8'hfe);
			8'h42: e = k2(3'd0, 8'hfe, 3'd7, 8'hf7);
			8'h62: e = k1(3'd7, 8'hf7);
			8'h43: e = k1(3'd0, 8'hee);
			8'h63: e = k1(3'd0, 8'hef);
			8'h44: e = k2(3'd0, 8'hfe, 3'd1, 8'hfb);
			8'h64: e = k1(3'd1, 8'hfb);
			8'h45: e = k2(3'd0, 8'hfe, 3'd2, 8'hfb);
			8'h65: e = k1(3'd2, 8'hfb);
			8'h46: e = k2(3'd0, 8'hfe, 3'd1, 8'hf7);
			8'h66: e = k1(3'd1, 8'hf7);
			8'h47: e = k2(3'd0, 8'hfe, 3'd1, 8'hef);
			8'h67: e = k1(3'd1, 8'hef);
			8'h48: e = k2(3'd0, 8'hfe, 3'd6, 8'hef);
			8'h68: e = k1(3'd6, 8'hef);
			8'h49: e = k2(3'd0, 8'hfe, 3'd5, 8'hfb);
			8'h69: e = k1(3'd5, 8'hfb);
			8'h4a: e = k2(3'd0, 8'hfe, 3'd6, 8'hf7);
			8'h6a: e = k1(3'd6, 8'hf7);
			8'h4b: e = k2(3'd0, 8'hfe, 3'd6, 8'hfb);
			8'h6b: e = k1(3'd6, 8'hfb);
			8'h4c: e = k2(3'd0, 8'hfe, 3'd6, 8'hfd);
			8'h6c: e = k1(3'd6, 8'hfd);
			8'h4d: e = k2(3'd0, 8'hfe, 3'd7, 8'hfd);
			8'h6d: e = k1(3'd7, 8'hfd);
			8'h4e: e = k2(3'd0, 8'hfe, 3'd7, 8'hfb);
			8'h6e: e = k1(3'd7, 8'hfb);
			8'h4f: e = k2(3'd0, 8'hfe, 3'd5, 8'hfd);
			8'h6f: e = k1(3'd5, 8'hfd);
			8'h50: e = k2(3'd0, 8'hfe, 3'd5, 8'hfe);
			8'h70: e = k1(3'd5, 8'hfe);
			8'h51: e = k2(3'd0, 8'hfe, 3'd2, 8'hfe);
			8'h71: e = k1(3'd2, 8'hfe);
			8'h52: e = k2(3'd0, 8'hfe, 3'd2, 8'hf7);
			8'h72: e = k1(3'd2, 8'hf7);
			8'h53: e = k2(3'd0, 8'hfe, 3'd1, 8'hfd);
			8'h73: e = k1(3'd1, 8'hfd);
			8'h54: e = k2(3'd0, 8'hfe, 3'd2, 8'hef);
			8'h74: e = k1(3'd2, 8'hef);
			8'h55: e = k2(3'd0, 8'hfe, 3'd5, 8'hf7);
			8'h75: e = k1(3'd5, 8'hf7);
			8'h56: e = k2(3'd0, 8'hfe, 3'd7, 8'hef);
			8'h76: e = k1(3'd7, 8'hef);
			8'h57: e = k2(3'd0, 8'hfe, 3'd2, 8'hfd);
			8'h77: e = k1(3'd2, 8'hfd);
			8'h58: e = k1(3'd0, 8'hf6);
			8'h78: e = k1(3'd0, 8'hf7);
			8'h59: e = k2(3'd0, 8'hfe, 3'd5, 8'hef);
			8'h79: e = k1(3'd5, 8'hef);
			8'h5a: e = k1(3'd0, 8'hfa);
			8'h80: e = k1(3'd0, 8'hfb); // lower-case z
			8'h3c: e = k2(3'd2, 8'hf7, 3'd0, 8'hfd);
			8'h3e: e = k2(3'd2, 8'hef, 3'd0, 8'hfd);
			8'h5b: e = k2(3'd5, 8'hef, 3'd0, 8'hfd);
			8'h5d: e = k2(3'd5, 8'hf7, 3'd0, 8'hfd);
			8'h60: e = k2(3'd5, 8'hfb, 3'd0, 8'hfd);
			8'h3b: e = k2(3'd5, 8'hfd, 3'd0, 8'hfd);
			8'h22: e = k2(3'd5, 8'hfe, 3'd0, 8'hfd);
			8'h7e: e = k2(3'd1, 8'hfe, 3'd0, 8'hfd);
			8'h7c: e = k2(3'd1, 8'hfd, 3'd0, 8'hfd);
			8'h5c: e = k2(3'd1, 8'hfb, 3'd0, 8'hfd);
			8'h7b: e = k2(3'd1, 8'hf7, 3'd0, 8'hfd);
			8'h7d: e = k2(3'd1, 8'hef, 3'd0, 8'hfd);
			8'h5e: e = k2(3'd6, 8'hef, 3'd0, 8'hfd);
			8'h2d: e = k2(3'd6, 8'hf7, 3'd0, 8'hfd);
			8'h2b: e = k2(3'd6, 8'hfb, 3'd0, 8'hfd);
			8'h3d: e = k2(3'd6, 8'hfd, 3'd0, 8'hfd);
			8'h0a: e = k1(3'd6, 8'hfe);
			8'h3a: e = k1(3'd0, 8'hf9);
			8'h9c: e = k1(3'd0, 8'hf5);
			8'h3f: e = k1(3'd0, 8'hed);
			8'h2f: e = k2(3'd7, 8'hef, 3'd0, 8'hfd);
			8'h2a: e = k2(3'd7, 8'hf7, 3'd0, 8'hfd);
			8'h2c: e = k2(3'd7, 8'hfb, 3'd0, 8'hfd);
			8'h2e: e = k2(3'd7, 8'hfd, 3'd0, 8'hfd);
			8'h20: e = k1(3'd7, 8'hfe);
			8'h09: e = k1(3'd7, 8'hfe);
			default: e = e;
		endcase
		return e;
	endfunction

endpackage

[hw/rtl/keyboard_matrix_port_unit.sv]
// ----------------------------------------------------------------------------
// Keyboard matrix port unit
// Eight-row active-low key matrix with key events, port reads and an
// auto-typing injector driven by scans of the matrix.
// ----------------------------------------------------------------------------
// Every item gives one result. An item is taken into an input register, then
// the key table lookup, row update, injector step and row read run
// combinationally into the result register, and one item is accepted every
// cycle while results are taken. A stalled result holds the input register
// only once it is full; the row state lives in flip-flops.
`include "keyboard_matrix_port_unit_defines.svh"

module keyboard_matrix_port_unit #(
	parameter int HOLD_SCANS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] key_code,
	input  logic [7:0] port_high,
	input  logic [7:0] port_low,
	input  logic [7:0] spool_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       spool_taken
);

	localparam logic [kmp_pkg::SCAN_W-1:0] HOLD = kmp_pkg::SCAN_W'(HOLD_SCANS);

	logic                       valid_s1;
	logic [1:0]                 kind_s1;
	logic [7:0]                 key_code_s1;
	logic [7:0]                 port_high_s1;
	logic [7:0]                 port_low_s1;
	logic [7:0]                 spool_char_s1;

	logic [7:0]                 rows_q [kmp_pkg::ROWS];
	logic [7:0]                 held_q;
	logic [kmp_pkg::SCAN_W-1:0] scans_q;
	logic                       out_valid_q;
	logic [7:0]                 read_data_q;
	logic                       spool_taken_q;

	logic                       advance;
	logic                       process;
	logic                       is_read;
	logic                       kb_read;
	logic                       inj_sel;
	logic                       inj_clear;
	logic                       inj_press;
	logic                       hold_dec;
	logic                       do_press;
	logic                       do_release;
	logic [7:0]                 lookup_code;
	kmp_pkg::key_entry_t        ent;
	logic [7:0]                 rows_d [kmp_pkg::ROWS];
	logic [7:0]                 held_d;
	logic [kmp_pkg::SCAN_W-1:0] scans_d;
	logic [7:0]                 data_d;

	assign advance  = !out_valid_q || out_ready;
	assign process  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	assign is_read   = (kmp_pkg::kind_t'(kind_s1) == kmp_pkg::KIND_READ);
	assign kb_read   = is_read && (port_low_s1 == kmp_pkg::KB_PORT);
	assign inj_sel   = kb_read && (port_high_s1 == kmp_pkg::INJECT_ROW_SEL) && (scans_q == '0);
	assign inj_clear = inj_sel && (held_q != 8'h00);
	assign inj_press = inj_sel && (held_q == 8'h00) && (spool_char_s1 != 8'h00);
	assign hold_dec  = kb_read && (port_high_s1 == kmp_pkg::HOLD_ROW_SEL) && (scans_q != '0);

	assign do_press   = (kmp_pkg::kind_t'(kind_s1) == kmp_pkg::KIND_PRESS) || inj_press;
	assign do_release = (kmp_pkg::kind_t'(kind_s1) == kmp_pkg::KIND_RELEASE);

	// injected characters go through the same table as key events
	assign lookup_code = is_read ? spool_char_s1 : key_code_s1;
	assign ent         = kmp_pkg::key_lookup(lookup_code);

	always_comb begin
		for (int r = 0; r < kmp_pkg::ROWS; r++) begin
			rows_d[r] = rows_q[r];
			if (inj_clear) begin
				rows_d[r] = kmp_pkg::IDLE_BYTE;
			end else begin
				if (ent.use1 && (ent.row1 == kmp_pkg::ROW_W'(r))) begin
					if (do_press) rows_d[r] = rows_d[r] & ent.mask1;
					else if (do_release) rows_d[r] = rows_d[r] | ~ent.mask1;
				end
				if (ent.use2 && (ent.row2 == kmp_pkg::ROW_W'(r))) begin
					if (do_press) rows_d[r] = rows_d[r] & ent.mask2;
					else if (do_release) rows_d[r] = rows_d[r] | ~ent.mask2;
				end
			end
		end
	end

	always_comb begin
		held_d  = held_q;
		scans_d = scans_q;
		if (inj_clear) begin
			held_d = 8'h00;
			if (held_q == kmp_pkg::NEWLINE) scans_d = HOLD;
		end else if (inj_press) begin
			held_d  = spool_char_s1;
			scans_d = HOLD;
		end else if (hold_dec) begin
			scans_d = scans_q - 1'b1;
		end
	end

	// row read sees this item's own update
	always_comb begin
		data_d = kmp_pkg::IDLE_BYTE;
		if (kb_read) begin
			for (int r = 0; r < kmp_pkg::ROWS; r++) begin
				if (port_high_s1 == ~(8'(1) << r)) data_d = rows_d[r];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1       <= kind;
			key_code_s1   <= key_code;
			port_high_s1  <= port_high;
			port_low_s1   <= port_low;
			spool_char_s1 <= spool_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < kmp_pkg::ROWS; r++) rows_q[r] <= kmp_pkg::IDLE_BYTE;
			held_q      <= 8'h00;
			scans_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (process) begin
				rows_q  <= rows_d;
				held_q  <= held_d;
				scans_q <= scans_d;
			end
			if (advance) out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			read_data_q   <= data_d;
			spool_taken_q <= inj_press;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign spool_taken = spool_taken_q;

	`KMP_ASSERT_NEXT(a_take_loads_hold, clk, arst_n, process && inj_press, (held_q != 8'h00) && (scans_q == HOLD))
	`KMP_ASSERT_NEXT(a_non_read_idle, clk, arst_n, process && !is_read, out_valid && (read_data == kmp_pkg::IDLE_BYTE) && !spool_taken)
	`KMP_ASSERT_NEXT(a_stall_holds_state, clk, arst_n, valid_s1 && out_valid && !out_ready, $stable(scans_q) && $stable(held_q))

endmodule

[tb/sv/tb_keyboard_matrix_port_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyboard matrix port unit testbench
// Drives key presses, key releases and port reads through the input channel
// and checks every reply against a matrix emulation kept in the bench or,
// for typed script rows, a fixed reply. It runs a short scripted sequence
// first, then about 1500 random accesses with sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_keyboard_matrix_port_unit;

	localparam int HOLD_SCANS = 4;
	localparam int KEY_COUNT  = 106;

	typedef struct packed {
		logic [7:0] read_data;
		logic       spool_taken;
	} port_reply_t;

	typedef struct packed {
		kmp_pkg::kind_t kind;
		logic [7:0]     key_code;
		logic [7:0]     port_high;
		logic [7:0]     port_low;
		logic [7:0]     spool_char;
		logic           typed;
		port_reply_t    reply;
	} script_row_t;

	// {code, row1, mask1, row2, mask2}; row2 of 8'hff means no second row
	localparam logic [KEY_COUNT-1:0][39:0] KEY_TAB = {
		40'h01_03_fe_00_fe, 40'h02_03_f7_00_fe, 40'h03_04_fd_00_fe,
		40'h04_03_ef_00_fe, 40'h05_04_f7_00_fe, 40'h06_04_ef_00_fe,
		40'h07_04_fb_00_fe, 40'h08_00_fe_04_fe,
		40'h31_03_fe_ff_00, 40'h32_03_fd_ff_00, 40'h33_03_fb_ff_00,
		40'h34_03_f7_ff_00, 40'h35_03_ef_ff_00, 40'h36_04_ef_ff_00,
		40'h37_04_f7_ff_00, 40'h38_04_fb_ff_00, 40'h39_04_fd_ff_00,
		40'h30_04_fe_ff_00,
		40'h21_03_fe_00_fd, 40'h40_03_fd_00_fd, 40'h23_03_fb_00_fd,
		40'h24_03_f7_00_fd, 40'h25_03_ef_00_fd,
		40'h26_07_fe_00_fe,
		40'h27_04_f7_00_fd, 40'h28_04_fb_00_fd, 40'h29_04_fd_00_fd,
		40'h5f_04_fe_00_fd,
		40'h41_00_fe_01_fe, 40'h61_01_fe_ff_00,
		40'h42_00_fe_07_f7, 40'h62_07_f7_ff_00,
		40'h43_00_ee_ff_00, 40'h63_00_ef_ff_00,
		40'h44_00_fe_01_fb, 40'h64_01_fb_ff_00,
		40'h45_00_fe_02_fb, 40'h65_02_fb_ff_00,
		40'h46_00_fe_01_f7, 40'h66_01_f7_ff_00,
		40'h47_00_fe_01_ef, 40'h67_01_ef_ff_00,
		40'h48_00_fe_06_ef, 40'h68_06_ef_ff_00,
		40'h49_00_fe_05_fb, 40'h69_05_fb_ff_00,
		40'h4a_00_fe_06_f7, 40'h6a_06_f7_ff_00,
		40'h4b_00_fe_06_fb, 40'h6b_06_fb_ff_00,
		40'h4c_00_fe_06_fd, 40'h6c_06_fd_ff_00,
		40'h4d_00_fe_07_fd, 40'h6d_07_fd_ff_00,
		40'h4e_00_fe_07_fb, 40'h6e_07_fb_ff_00,
		40'h4f_00_fe_05_fd, 40'h6f_05_fd_ff_00,
		40'h50_00_fe_05_fe, 40'h70_05_fe_ff_00,
		40'h51_00_fe_02_fe, 40'h71_02_fe_ff_00,
		40'h52_00_fe_02_f7, 40'h72_02_f7_ff_00,
		40'h53_00_fe_01_fd, 40'h73_01_fd_ff_00,
		40'h54_00_fe_02_ef, 40'h74_02_ef_ff_00,
		40'h55_00_fe_05_f7, 40'h75_05_f7_ff_00,
		40'h56_00_fe_07_ef, 40'h76_07_ef_ff_00,
		40'h57_00_fe_02_fd, 40'h77_02_fd_ff_00,
		40'h58_00_f6_ff_00, 40'h78_00_f7_ff_00,
		40'h59_00_fe_05_ef, 40'h79_05_ef_ff_00,
		40'h5a_00_fa_ff_00, 40'h80_00_fb_ff_00,
		40'h3c_02_f7_00_fd, 40'h3e_02_ef_00_fd, 40'h5b_05_ef_00_fd,
		40'h5d_05_f7_00_fd, 40'h60_05_fb_00_fd, 40'h3b_05_fd_00_fd,
		40'h22_05_fe_00_fd, 40'h7e_01_fe_00_fd, 40'h7c_01_fd_00_fd,
		40'h5c_01_fb_00_fd, 40'h7b_01_f7_00_fd, 40'h7d_01_ef_00_fd,
		40'h5e_06_ef_00_fd, 40'h2d_06_f7_00_fd, 40'h2b_06_fb_00_fd,
		40'h3d_06_fd_00_fd,
		40'h0a_06_fe_ff_00, 40'h3a_00_f9_ff_00, 40'h9c_00_f5_ff_00,
		40'h3f_00_ed_ff_00,
		40'h2f_07_ef_00_fd, 40'h2a_07_f7_00_fd, 40'h2c_07_fb_00_fd,
		40'h2e_07_fd_00_fd,
		40'h20_07_fe_ff_00, 40'h09_07_fe_ff_00
	};

	localparam int SCRIPT_LEN = 27;
	localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfe, 8'hfe, 8'h00, 1'b1, '{8'hff, 1'b0}},
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfe, 8'h00, 8'h00, 1'b1, '{8'hff, 1'b0}},
		'{kmp_pkg::KIND_READ,    8'hff, 8'hff, 8'hff, 8'hff, 1'b1, '{8'hff, 1'b0}},
		'{kmp_pkg::KIND_NONE,    8'hff, 8'hff, 8'hfe, 8'hff, 1'b1, '{8'hff, 1'b0}},
		// Break shares its code; it hits row 7 and row 0
		'{kmp_pkg::KIND_PRESS,   8'h26, 8'h00, 8'h00, 8'h00, 1'b1, '{8'hff, 1'b0}},
		'{kmp_pkg::KIND_READ,    8'h00, 8'h7f, 8'hfe, 8'h00, 1'b1, '{8'hfe, 1'b0}},
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfe, 8'hfe, 8'h00, 1'b1, '{8'hfe, 1'b0}},
		'{kmp_pkg::KIND_RELEASE, 8'h26, 8'h00, 8'h00, 8'h00, 1'b1, '{8'hff, 1'b0}},
		'{kmp_pkg::KIND_PRESS,   8'h7a, 8'h00, 8'h00, 8'h00, 1'b1, '{8'hff, 1'b0}},
		'{kmp_pkg::KIND_PRESS,   8'h80, 8'h00, 8'h00, 8'h00, 1'b1, '{8'hff, 1'b0}},
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfe, 8'hfe, 8'h00, 1'b1, '{8'hfb, 1'b0}},
		'{kmp_pkg::KIND_RELEASE, 8'h80, 8'h00, 8'h00, 8'h00, 1'b1, '{8'hff, 1'b0}},
		'{kmp_pkg::KIND_PRESS,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '{8'hff, 1'b0}},
		'{kmp_pkg::KIND_READ,    8'h00, 8'h00, 8'hfe, 8'h00, 1'b1, '{8'hff, 1'b0}},
		// injector takes a character and holds it
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfe, 8'hfe, 8'h41, 1'b1, '{8'hfe, 1'b1}},
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfd, 8'hfe, 8'h00, 1'b0, '{8'h00, 1'b0}},
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfd, 8'hfe, 8'h00, 1'b0, '{8'h00, 1'b0}},
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfd, 8'hfe, 8'h00, 1'b0, '{8'h00, 1'b0}},
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfd, 8'hfe, 8'h00, 1'b0, '{8'h00, 1'b0}},
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfe, 8'hfe, 8'h42, 1'b1, '{8'hff, 1'b0}},
		// newline gets a second hold after the rows clear
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfe, 8'hfe, 8'h0a, 1'b0, '{8'h00, 1'b0}},
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfd, 8'hfe, 8'h00, 1'b0, '{8'h00, 1'b0}},
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfd, 8'hfe, 8'h00, 1'b0, '{8'h00, 1'b0}},
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfd, 8'hfe, 8'h00, 1'b0, '{8'h00, 1'b0}},
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfd, 8'hfe, 8'h00, 1'b0, '{8'h00, 1'b0}},
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfe, 8'hfe, 8'h00, 1'b0, '{8'h00, 1'b0}},
		'{kmp_pkg::KIND_READ,    8'h00, 8'hfe, 8'hfe, 8'h55, 1'b0, '{8'h00, 1'b0}}
	};

	logic           clk;
	logic           arst_n      = 1'b0;
	logic           in_valid    = 1'b0;
	logic           in_ready;
	kmp_pkg::kind_t kind        = kmp_pkg::KIND_NONE;
	logic [7:0]     key_code    = 8'h00;
	logic [7:0]     port_high   = 8'hff;
	logic [7:0]     port_low    = 8'h00;
	logic [7:0]     spool_char  = 8'h00;
	logic           out_valid;
	logic           out_ready   = 1'b0;
	logic [7:0]     read_data;
	logic           spool_taken;

	// emulated matrix
	logic [7:0] mx_rows [kmp_pkg::ROWS];
	logic [7:0] mx_held  = 8'h00;
	logic [2:0] mx_scans = 3'd0;

	port_reply_t awaited_replies [$];
	int  fail_count    = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	logic long_hold_req = 1'b0;
	int  n_items = 0;
	int  n_reads = 0;
	int  n_keys  = 0;
	int  n_typed = 0;

	keyboard_matrix_port_unit #(
		.HOLD_SCANS(HOLD_SCANS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.key_code(key_code),
		.port_high(port_high),
		.port_low(port_low),
		.spool_char(spool_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.spool_taken(spool_taken)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	// first table entry with a matching code wins
	function automatic void key_event(input logic [7:0] code, input logic down);
		logic [39:0] ent;
		logic        hit;
		logic [7:0]  row;
		logic [7:0]  mask;
		hit = 1'b0;
		ent = '0;
		for (int i = KEY_COUNT - 1; i >= 0; i--) begin
			if (!hit && KEY_TAB[i][39:32] == code) begin
				hit = 1'b1;
				ent = KEY_TAB[i];
			end
		end
		if (hit) begin
			for (int h = 0; h < 2; h++) begin
				row  = (h == 0) ? ent[31:24] : ent[15:8];
				mask = (h == 0) ? ent[23:16] : ent[7:0];
				if (row < 8'(kmp_pkg::ROWS)) begin
					if (down)
						mx_rows[row[2:0]] = mx_rows[row[2:0]] & mask;
					else
						mx_rows[row[2:0]] = mx_rows[row[2:0]] | ~mask;
				end
			end
		end
	endfunction

	function automatic port_reply_t emulate_access(input kmp_pkg::kind_t k,
			input logic [7:0] code, input logic [7:0] hi, input logic [7:0] lo,
			input logic [7:0] sc);
		port_reply_t r;
		r.read_data   = kmp_pkg::IDLE_BYTE;
		r.spool_taken = 1'b0;
		case (k)
			kmp_pkg::KIND_PRESS: key_event(code, 1'b1);
			kmp_pkg::KIND_RELEASE: key_event(code, 1'b0);
			kmp_pkg::KIND_READ: begin
				if (lo == kmp_pkg::KB_PORT && hi == kmp_pkg::INJECT_ROW_SEL
						&& mx_scans == 3'd0) begin
					if (mx_held != 8'h00) begin
						for (int i = 0; i < kmp_pkg::ROWS; i++)
							mx_rows[i] = kmp_pkg::IDLE_BYTE;
						if (mx_held == kmp_pkg::NEWLINE)
							mx_scans = 3'(HOLD_SCANS);
						mx_held = 8'h00;
					end else if (sc != 8'h00) begin
						key_event(sc, 1'b1);
						mx_held       = sc;
						mx_scans      = 3'(HOLD_SCANS);
						r.spool_taken = 1'b1;
					end
				end else if (lo == kmp_pkg::KB_PORT && hi == kmp_pkg::HOLD_ROW_SEL
						&& mx_scans != 3'd0) begin
					mx_scans = mx_scans - 3'd1;
				end
				// row is read after the injector update
				if (lo == kmp_pkg::KB_PORT) begin
					for (int i = 0; i < kmp_pkg::ROWS; i++)
						if (hi == ~(8'd1 << i))
							r.read_data = mx_rows[i];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// holds the item until accepted, then maybe idles the sender a while
	task automatic send_access(input kmp_pkg::kind_t k, input logic [7:0] code,
			input logic [7:0] hi, input logic [7:0] lo, input logic [7:0] sc,
			input logic typed, input port_reply_t fixed);
		port_reply_t r;
		in_valid   <= 1'b1;
		kind       <= k;
		key_code   <= code;
		port_high  <= hi;
		port_low   <= lo;
		spool_char <= sc;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = emulate_access(k, code, hi, lo, sc);
		awaited_replies.push_back(typed ? fixed : r);
		n_items++;
		if (k == kmp_pkg::KIND_READ)
			n_reads++;
		if (k == kmp_pkg::KIND_PRESS || k == kmp_pkg::KIND_RELEASE)
			n_keys++;
		if (r.spool_taken)
			n_typed++;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
	endtask

	task automatic await_replies();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	// receiver: checks replies and drives out_ready
	initial begin
		port_reply_t want;
		int          hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (awaited_replies.size() == 0) begin
					$error("reply with none pending: read_data %h spool_taken %b",
						read_data, spool_taken);
					fail_count++;
				end else begin
					want = awaited_replies.pop_front();
					if (read_data !== want.read_data) begin
						$error("read_data: expected %h, got %h", want.read_data, read_data);
						fail_count++;
					end
					if (spool_taken !== want.spool_taken) begin
						$error("spool_taken: expected %b, got %b",
							want.spool_taken, spool_taken);
						fail_count++;
					end
				end
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = 63;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		kmp_pkg::kind_t k;
		logic [7:0]     code;
		logic [7:0]     hi;
		logic [7:0]     lo;
		logic [7:0]     sc;
		logic [7:0]     tcode;
		int             sel;
		int             pick;
		for (int i = 0; i < kmp_pkg::ROWS; i++)
			mx_rows[i] = kmp_pkg::IDLE_BYTE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++)
			send_access(SCRIPT[i].kind, SCRIPT[i].key_code, SCRIPT[i].port_high,
				SCRIPT[i].port_low, SCRIPT[i].spool_char, SCRIPT[i].typed,
				SCRIPT[i].reply);
		await_replies();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 50 : 0;
			recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 22 : 0;
			for (int n = 0; n < 500; n++) begin
				// long receiver stall while items keep coming
				if (ph == 0 && n == 150)
					long_hold_req = 1'b1;
				sel   = $urandom_range(99);
				pick  = $urandom_range(9);
				tcode = KEY_TAB[$urandom_range(KEY_COUNT - 1)][39:32];
				k     = kmp_pkg::KIND_READ;
				code  = 8'($urandom_range(255));
				hi    = 8'($urandom_range(255));
				lo    = kmp_pkg::KB_PORT;
				sc    = 8'($urandom_range(255));
				if (sel < 35) begin
					hi = kmp_pkg::INJECT_ROW_SEL;
					if (pick < 2)
						sc = 8'h00;
					else if (pick == 2)
						sc = kmp_pkg::NEWLINE;
					else if (pick < 8)
						sc = tcode;
				end else if (sel < 65) begin
					hi = kmp_pkg::HOLD_ROW_SEL;
				end else if (sel < 80) begin
					hi = ~(8'd1 << $urandom_range(7));
				end else if (sel < 92) begin
					k = (sel % 2 == 0) ? kmp_pkg::KIND_PRESS : kmp_pkg::KIND_RELEASE;
					if (pick < 8)
						code = tcode;
				end else begin
					k  = kmp_pkg::kind_t'($urandom_range(3));
					lo = 8'($urandom_range(255));
				end
				send_access(k, code, hi, lo, sc, 1'b0, '0);
			end
			// sender waits here until every reply is in
			await_replies();
		end

		recv_idle_pct = 0;
		repeat (8) @(posedge clk);
		$display("%0d items sent: %0d port reads, %0d key events", n_items, n_reads, n_keys);
		$display("%0d characters typed by the injector, long receiver stall included",
			n_typed);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
